// File: sv/bdqi_pkg.sv
// Shared opcodes, status codes and controller/datapath interface types for the deque.
package bdqi_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned IDX_W  = 8;
  localparam int unsigned STS_W  = 2;

  typedef enum logic [2:0] {
    OP_PUSH_BACK  = 3'd0,
    OP_PUSH_FRONT = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_REMOVE_AT  = 3'd4,
    OP_READ_AT    = 3'd5,
    OP_CLEAR      = 3'd6,
    OP_NOP        = 3'd7
  } op_t;

  typedef enum logic [STS_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2,
    ST_RSVD  = 2'd3
  } status_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic start;        // a transaction is accepted this cycle
    logic read_done;    // first memory read data is available
    logic shift_rd;     // read the entry behind the gap
    logic shift_wr;     // move that entry one place toward the front
    logic remove_done;  // gap closed, shrink the queue
  } dq_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic needs_read;   // the offered transaction reads the memory
    logic op_remove;    // the operation in flight is a removal
    logic shift_more;   // entries remain to be moved
  } dq_sts_t;

endpackage

// File: sv/bdqi_ctrl.sv
// Controller state machine: handshakes, sequencing of reads and the removal shift.
module bdqi_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  bdqi_pkg::dq_sts_t sts,
  output bdqi_pkg::dq_cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE     = 4'b0001,
    S_READ     = 4'b0010,
    S_SHIFT_RD = 4'b0100,
    S_SHIFT_WR = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   load;

  // A new transaction enters only when idle and the result register is free or draining.
  assign in_stall  = (state_r != S_IDLE) || (out_valid_r && out_stall);
  assign out_valid = out_valid_r;

  // Next state and command decode.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    load      = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        cmd.start = in_valid && !in_stall;
        if (cmd.start) begin
          if (sts.needs_read) begin
            state_nxt = S_READ;
          end else begin
            load = 1'b1;
          end
        end
      end
      S_READ: begin
        cmd.read_done = 1'b1;
        if (sts.op_remove) begin
          state_nxt = S_SHIFT_RD;
        end else begin
          load      = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_SHIFT_RD: begin
        if (sts.shift_more) begin
          cmd.shift_rd = 1'b1;
          state_nxt    = S_SHIFT_WR;
        end else begin
          cmd.remove_done = 1'b1;
          load            = 1'b1;
          state_nxt       = S_IDLE;
        end
      end
      S_SHIFT_WR: begin
        cmd.shift_wr = 1'b1;
        state_nxt    = S_SHIFT_RD;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // The result register holds until the consumer takes it.
  assign out_valid_nxt = load ? 1'b1 : (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// File: sv/bdqi_dp.sv
// Datapath: ring memory, front pointer, entry count, shift cursor and result registers.
module bdqi_dp #(
  parameter int unsigned DEPTH = 256
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic [2:0]                            in_opcode,
  input  logic signed [bdqi_pkg::WORD_W-1:0]    in_value,
  input  logic [bdqi_pkg::IDX_W-1:0]            in_index,
  output logic signed [bdqi_pkg::WORD_W-1:0]    out_result_value,
  output logic [bdqi_pkg::STS_W-1:0]            out_status,
  output logic [$clog2(DEPTH+1)-1:0]            out_count,
  output logic                                  out_is_empty,
  input  bdqi_pkg::dq_cmd_t                     cmd,
  output bdqi_pkg::dq_sts_t                     sts
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned CMP_W = (CNT_W > bdqi_pkg::IDX_W) ? CNT_W : bdqi_pkg::IDX_W;
  localparam logic [PTR_W:0]   DEPTH_S = (PTR_W + 1)'(DEPTH);
  localparam logic [PTR_W-1:0] LAST    = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL    = CNT_W'(DEPTH);

  // Ring position of an entry counted from the front.
  function automatic logic [PTR_W-1:0] slot_of(input logic [PTR_W-1:0] front,
                                               input logic [PTR_W-1:0] pos);
    logic [PTR_W:0] sum;
    sum = {1'b0, front} + {1'b0, pos};
    if (sum >= DEPTH_S) begin
      sum = sum - DEPTH_S;
    end
    return sum[PTR_W-1:0];
  endfunction

  logic [bdqi_pkg::WORD_W-1:0] mem [DEPTH];
  logic [bdqi_pkg::WORD_W-1:0] rd_data_r;

  logic [PTR_W-1:0] front_r, front_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [PTR_W-1:0] cur_r, cur_nxt;
  bdqi_pkg::op_t    op_r;
  logic [PTR_W-1:0] idx_pos_r;
  logic [bdqi_pkg::WORD_W-1:0] held_r;

  logic                        wr_en, rd_en;
  logic [PTR_W-1:0]            wr_addr, rd_addr;
  logic [bdqi_pkg::WORD_W-1:0] wr_data;

  logic                        out_load;
  logic [bdqi_pkg::WORD_W-1:0] out_val_nxt;
  bdqi_pkg::status_t           out_sts_nxt;

  bdqi_pkg::op_t    op_in;
  logic [CMP_W-1:0] idx_ext;
  logic [PTR_W-1:0] idx_pos;
  logic             is_full, is_none, idx_bad;
  logic [CNT_W-1:0] cur_plus;

  assign op_in    = bdqi_pkg::op_t'(in_opcode);
  assign idx_ext  = CMP_W'(in_index);
  assign idx_pos  = idx_ext[PTR_W-1:0];
  assign is_full  = (count_r == FULL);
  assign is_none  = (count_r == '0);
  assign idx_bad  = (idx_ext >= CMP_W'(count_r));
  assign cur_plus = CNT_W'(cur_r) + CNT_W'(1);

  // Status toward the controller.
  always_comb begin
    sts.needs_read = 1'b0;
    unique case (op_in)
      bdqi_pkg::OP_POP_FRONT,
      bdqi_pkg::OP_POP_BACK:  sts.needs_read = !is_none;
      bdqi_pkg::OP_REMOVE_AT,
      bdqi_pkg::OP_READ_AT:   sts.needs_read = !idx_bad;
      default:                sts.needs_read = 1'b0;
    endcase
    sts.op_remove  = (op_r == bdqi_pkg::OP_REMOVE_AT);
    sts.shift_more = (cur_plus < count_r);
  end

  // Pointer, count, memory access and result selection.
  always_comb begin
    front_nxt   = front_r;
    count_nxt   = count_r;
    cur_nxt     = cur_r;
    wr_en       = 1'b0;
    wr_addr     = slot_of(front_r, cur_r);
    wr_data     = rd_data_r;
    rd_en       = 1'b0;
    rd_addr     = slot_of(front_r, cur_plus[PTR_W-1:0]);
    out_load    = 1'b0;
    out_val_nxt = '0;
    out_sts_nxt = bdqi_pkg::ST_OK;

    if (cmd.start) begin
      out_load = !sts.needs_read;
      unique case (op_in)
        bdqi_pkg::OP_PUSH_BACK: begin
          if (is_full) begin
            out_sts_nxt = bdqi_pkg::ST_FULL;
          end else begin
            wr_en     = 1'b1;
            wr_addr   = slot_of(front_r, count_r[PTR_W-1:0]);
            wr_data   = in_value;
            count_nxt = count_r + CNT_W'(1);
          end
        end
        bdqi_pkg::OP_PUSH_FRONT: begin
          if (is_full) begin
            out_sts_nxt = bdqi_pkg::ST_FULL;
          end else begin
            front_nxt = (front_r == '0) ? LAST : front_r - PTR_W'(1);
            wr_en     = 1'b1;
            wr_addr   = front_nxt;
            wr_data   = in_value;
            count_nxt = count_r + CNT_W'(1);
          end
        end
        bdqi_pkg::OP_POP_FRONT: begin
          if (is_none) begin
            out_sts_nxt = bdqi_pkg::ST_RANGE;
            out_val_nxt = bdqi_pkg::WORD_W'(1);
          end else begin
            rd_en     = 1'b1;
            rd_addr   = front_r;
            front_nxt = (front_r == LAST) ? '0 : front_r + PTR_W'(1);
            count_nxt = count_r - CNT_W'(1);
          end
        end
        bdqi_pkg::OP_POP_BACK: begin
          if (is_none) begin
            out_sts_nxt = bdqi_pkg::ST_RANGE;
            out_val_nxt = bdqi_pkg::WORD_W'(1);
          end else begin
            count_nxt = count_r - CNT_W'(1);
            rd_en     = 1'b1;
            rd_addr   = slot_of(front_r, count_nxt[PTR_W-1:0]);
          end
        end
        bdqi_pkg::OP_REMOVE_AT,
        bdqi_pkg::OP_READ_AT: begin
          if (idx_bad) begin
            out_sts_nxt = bdqi_pkg::ST_RANGE;
            out_val_nxt = bdqi_pkg::WORD_W'(1);
          end else begin
            rd_en   = 1'b1;
            rd_addr = slot_of(front_r, idx_pos);
          end
        end
        bdqi_pkg::OP_CLEAR: begin
          front_nxt = '0;
          count_nxt = '0;
        end
        default: begin
        end
      endcase
    end

    // First read returned: deliver it, or start closing the gap.
    if (cmd.read_done) begin
      cur_nxt     = idx_pos_r;
      out_load    = !sts.op_remove;
      out_val_nxt = rd_data_r;
    end

    if (cmd.shift_rd) begin
      rd_en = 1'b1;
    end

    if (cmd.shift_wr) begin
      wr_en   = 1'b1;
      cur_nxt = cur_plus[PTR_W-1:0];
    end

    if (cmd.remove_done) begin
      count_nxt   = count_r - CNT_W'(1);
      out_load    = 1'b1;
      out_val_nxt = held_r;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r <= '0;
      count_r <= '0;
    end else begin
      front_r <= front_nxt;
      count_r <= count_nxt;
    end
  end

  // Operation context, shift cursor and removed word.
  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    if (cmd.start) begin
      op_r      <= op_in;
      idx_pos_r <= idx_pos;
    end
    if (cmd.read_done) begin
      held_r <= rd_data_r;
    end
  end

  // Ring memory with a registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_result_value <= out_val_nxt;
      out_status       <= out_sts_nxt;
      out_count        <= count_nxt;
      out_is_empty     <= (count_nxt == '0);
    end
  end

endmodule

// File: sv/bounded_deque_indexed_top.sv
// Top level of the bounded double-ended queue with indexed access.
// Each transaction carries one operation; each gives one result transaction. Push, clear
// and any rejected operation read no memory: the result is registered at acceptance.
// Pop front, pop back and read at pass through S_READ because the ring memory registers
// its read data. Remove at an index reads the indexed entry, then every later entry is read
// and written back one place nearer the front, in S_SHIFT_RD and then S_SHIFT_WR for each entry.
// One transaction is in flight at a time; the result register lets the next transaction enter in
// the cycle the previous result is taken.
module bounded_deque_indexed_top #(
  parameter int unsigned DEPTH = 256
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [2:0]                            in_opcode,
  input  logic signed [bdqi_pkg::WORD_W-1:0]    in_value,
  input  logic [bdqi_pkg::IDX_W-1:0]            in_index,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [bdqi_pkg::WORD_W-1:0]    out_result_value,
  output logic [bdqi_pkg::STS_W-1:0]            out_status,
  output logic [$clog2(DEPTH+1)-1:0]            out_count,
  output logic                                  out_is_empty
);

  bdqi_pkg::dq_cmd_t cmd;
  bdqi_pkg::dq_sts_t sts;

  bdqi_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  bdqi_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_opcode        (in_opcode),
    .in_value         (in_value),
    .in_index         (in_index),
    .out_result_value (out_result_value),
    .out_status       (out_status),
    .out_count        (out_count),
    .out_is_empty     (out_is_empty),
    .cmd              (cmd),
    .sts              (sts)
  );

endmodule
